// File: design/utfgl_pkg.sv
package utfgl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int CMD_FIFO_DEPTH  = 4;
  localparam int CNT_W           = 9;

  localparam logic [7:0] NO_GLYPH   = 8'd63;
  localparam logic [7:0] ASCII_LIM  = 8'd128;
  localparam logic [3:0] LEAD_TWO   = 4'hC;
  localparam logic [3:0] LEAD_THREE = 4'hE;
  localparam logic [3:0] LEAD_FOUR  = 4'hF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  table_slot;
    logic [31:0] table_word;
    logic [7:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] glyph_index;
    logic [2:0] bytes_used;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SEARCH,
    CMD_FIXED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  slot;
    logic [31:0] word;
    logic [2:0]  bytes;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } back_state_t;

endpackage

// File: design/utfgl_front.sv
module utfgl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  utfgl_pkg::in_item_t item,
  output logic            cmd_push,
  output utfgl_pkg::cmd_t cmd
);
  import utfgl_pkg::*;

  logic [31:0] acc, acc_next;
  logic [2:0]  expected, expected_next;
  logic [2:0]  held, held_next;
  logic [31:0] shifted;
  logic [2:0]  held_inc;

  assign shifted  = {acc[23:0], item.text_byte};
  assign held_inc = held + 3'd1;

  always_comb begin
    acc_next      = acc;
    expected_next = expected;
    held_next     = held;
    cmd_push      = 1'b0;
    cmd.kind      = CMD_LOAD;
    cmd.slot      = item.table_slot;
    cmd.word      = item.table_word;
    cmd.bytes     = 3'd1;
    if (accept) begin
      if (item.operation == OP_LOAD) begin
        cmd_push = 1'b1;
      end else if (expected != 3'd0) begin
        // continuation bytes are packed whatever their value
        acc_next  = shifted;
        held_next = held_inc;
        if (held_inc == expected) begin
          cmd_push      = 1'b1;
          cmd.kind      = CMD_SEARCH;
          cmd.word      = shifted;
          cmd.bytes     = expected;
          acc_next      = '0;
          expected_next = '0;
          held_next     = '0;
        end
      end else if (item.text_byte < ASCII_LIM) begin
        cmd_push = 1'b1;
        cmd.kind = CMD_SEARCH;
        cmd.word = {24'd0, item.text_byte};
      end else begin
        unique case (item.text_byte[7:4])
          LEAD_TWO:   expected_next = 3'd2;
          LEAD_THREE: expected_next = 3'd3;
          LEAD_FOUR:  expected_next = 3'd4;
          default: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_FIXED;
          end
        endcase
        if (expected_next != 3'd0) begin
          acc_next  = {24'd0, item.text_byte};
          held_next = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      expected <= '0;
      held     <= '0;
    end else begin
      acc      <= acc_next;
      expected <= expected_next;
      held     <= held_next;
    end
  end

endmodule

// File: design/utfgl_cmd_fifo.sv
module utfgl_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utfgl_pkg::cmd_t push_data,
  input  logic            pop,
  output utfgl_pkg::cmd_t head,
  output logic            not_empty,
  output logic            full
);
  import utfgl_pkg::*;

  localparam int PW = $clog2(CMD_FIFO_DEPTH);

  cmd_t          slots [CMD_FIFO_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign head      = slots[rptr];
  assign not_empty = (count != '0);
  assign full      = (count == (PW+1)'(CMD_FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// File: design/utfgl_back.sv
module utfgl_back #(
  parameter int TABLE_DEPTH = utfgl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [utfgl_pkg::CNT_W-1:0]  table_size,
  input  logic                         cmd_valid,
  input  utfgl_pkg::cmd_t              cmd,
  output logic                         cmd_pop,
  output logic                         empty,
  input  logic                         pop,
  output utfgl_pkg::out_item_t         result
);
  import utfgl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [31:0]      glyph_codes [TABLE_DEPTH];
  logic [31:0]      rd_data;
  back_state_t      state, state_next;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             rd_valid, rd_valid_next;
  logic [31:0]      code, code_next;
  logic [2:0]       bytes, bytes_next;
  logic [7:0]       res, res_next;
  logic             mem_we;
  logic             out_valid;
  logic             out_load;
  logic             hit, last;

  assign limit = (table_size > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : table_size;
  assign hit   = rd_valid && (rd_data == code);
  assign last  = rd_valid && (rd_idx == limit - 1'b1);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_codes[cmd.slot[AW-1:0]] <= cmd.word;
    end
    rd_data <= glyph_codes[idx[AW-1:0]];
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    rd_idx_next   = rd_idx;
    rd_valid_next = 1'b0;
    code_next     = code;
    bytes_next    = bytes;
    res_next      = res;
    mem_we        = 1'b0;
    cmd_pop       = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LOAD: begin
              mem_we = ({1'b0, cmd.slot} < CNT_W'(TABLE_DEPTH));
            end
            CMD_SEARCH: begin
              code_next  = cmd.word;
              bytes_next = cmd.bytes;
              idx_next   = '0;
              if (limit == '0) begin
                res_next   = NO_GLYPH;
                state_next = B_EMIT;
              end else begin
                state_next = B_SCAN;
              end
            end
            CMD_FIXED: begin
              res_next   = NO_GLYPH;
              bytes_next = cmd.bytes;
              state_next = B_EMIT;
            end
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        // one read issued per cycle, compared in the cycle after it is issued
        if (hit) begin
          res_next   = rd_idx[7:0];
          state_next = B_EMIT;
        end else if (last) begin
          res_next   = NO_GLYPH;
          state_next = B_EMIT;
        end else if (idx < limit) begin
          rd_valid_next = 1'b1;
          rd_idx_next   = idx;
          idx_next      = idx + 1'b1;
        end
      end
      B_EMIT: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      rd_valid <= 1'b0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_valid_next;
      idx      <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    code   <= code_next;
    bytes  <= bytes_next;
    res    <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.glyph_index <= res;
      result.bytes_used  <= bytes;
    end
  end

endmodule

// File: design/utf8_glyph_index_lookup_top.sv
// UTF-8 text to font glyph index lookup.
// Input queue: drive item and raise push; the item is taken on a clock edge
// with push high and full low. An item either loads one table entry
// (operation 0) or carries one text byte (operation 1).
// Result queue: while empty is low, result holds the oldest glyph index and
// the byte count of its character; raise pop to take it.
// cfg_we/cfg_data set table_size, the number of entries searched from
// entry 0; write it only while no character is in flight.
// A character's last byte goes into the command queue; the scan engine then
// reads entries from 0 up to N = min(table_size, TABLE_DEPTH), stopping at
// the first match, one entry per cycle from a single memory read port, and
// registers the result; it finishes one command before taking the next.
// A four-deep command queue lets text and loads keep flowing while a scan
// runs or a result waits; when the result is not popped the scan engine
// holds, the queue fills and full rises.
// Reset clears the character assembler, the queue, the result valid flag and
// table_size; table contents stay undefined until loaded.
module utf8_glyph_index_lookup_top #(
  parameter int TABLE_DEPTH = utfgl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  utfgl_pkg::in_item_t         item,
  output logic                        empty,
  input  logic                        pop,
  output utfgl_pkg::out_item_t        result,
  input  logic                        cfg_we,
  input  logic [utfgl_pkg::CNT_W-1:0] cfg_data
);
  import utfgl_pkg::*;

  logic             accept;
  logic             cmd_push;
  cmd_t             cmd_in;
  cmd_t             cmd_head;
  logic             cmd_valid;
  logic             cmd_pop;
  logic [CNT_W-1:0] table_size;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  utfgl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  utfgl_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .not_empty (cmd_valid),
    .full      (full)
  );

  utfgl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .table_size (table_size),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.bytes_used >= 3'd1 && result.bytes_used <= 3'd4))
    else $error("result byte count out of range");

  a_hit_in_table: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.glyph_index != NO_GLYPH) |->
      ({1'b0, result.glyph_index} < table_size))
    else $error("matched index beyond searched table");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

// File: tb/sv/tb_utf8_glyph_index_lookup_top.sv
`timescale 1ns / 1ps

module tb_utf8_glyph_index_lookup_top;
  import utfgl_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int REPORT_MAX = 10;
  localparam int PHASES = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CNT_W-1:0] size;
    in_item_t         it;
    logic             typed_exp;
    out_item_t        want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  in_item_t         item = '0;
  logic             empty;
  logic             pop = 1'b0;
  out_item_t        result;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  // predictor state
  logic [31:0]      font_codes [DEPTH];
  logic [31:0]      char_acc = '0;
  logic [2:0]       char_len = '0;
  logic [2:0]       char_got = '0;
  logic [CNT_W-1:0] search_len = '0;
  out_item_t        due_glyphs [$];
  int               due_head = 0;

  int     bad_count = 0;
  int     sent = 0;
  int     rx_stall = 0;
  int     rx_gap = 0;
  int     pops_seen = 0;
  int     pops_done = 0;
  bit     quiet = 1'b0;
  longint cycle_count = 0;

  // size 0 rows and invalid leads carry their result inline
  plan_row_t dir_plan [27] = '{
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h00}, 1'b1, '{NO_GLYPH, 3'd1}},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'hFF, 32'hFFFFFFFF, 8'h7F}, 1'b1, '{NO_GLYPH, 3'd1}},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h80}, 1'b1, '{NO_GLYPH, 3'd1}},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hDF}, 1'b1, '{NO_GLYPH, 3'd1}},
    '{ROW_ITEM, 9'd0, '{OP_LOAD, 8'd0, 32'h00000041, 8'hFF}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_LOAD, 8'd1, 32'h0000C3A9, 8'h00}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_LOAD, 8'd2, 32'h00E282AC, 8'h00}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_LOAD, 8'd3, 32'hF09F9880, 8'h00}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_LOAD, 8'd4, 32'hFFFFFFFF, 8'h00}, 1'b0, '0},
    '{ROW_CFG,  9'd5, '{OP_LOAD, 8'd0, 32'h0, 8'h00}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h41}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hC3}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hA9}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hE2}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h82}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hAC}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hF0}, 1'b0, '0},
    // table write in the middle of a character
    '{ROW_ITEM, 9'd0, '{OP_LOAD, 8'd255, 32'h00000000, 8'h00}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h9F}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h98}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h80}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hFF}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hFF}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hFF}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hFF}, 1'b0, '0},
    // trailing byte is not a continuation byte; packs to C341, no match
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'hC3}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_TEXT, 8'h00, 32'h0, 8'h41}, 1'b1, '{NO_GLYPH, 3'd2}}
  };

  logic [CNT_W-1:0] phase_size [PHASES] =
    '{9'd256, 9'd511, 9'd1, 9'd0, 9'd17, 9'd300, 9'd8, 9'd3, 9'd64, 9'd2};
  int phase_items [PHASES] = '{120, 80, 150, 100, 200, 60, 200, 150, 120, 100};

  utf8_glyph_index_lookup_top uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int search_span();
    return (search_len > DEPTH) ? DEPTH : int'(search_len);
  endfunction

  function automatic logic [7:0] match_code(logic [31:0] code);
    int lim;
    lim = search_span();
    for (int k = 0; k < lim; k++)
      if (font_codes[k[7:0]] == code) return k[7:0];
    return NO_GLYPH;
  endfunction

  // returns 1 when the item completes a character
  function automatic bit next_glyph(input in_item_t it, output out_item_t res);
    res = '0;
    if (it.operation == OP_LOAD) begin
      font_codes[it.table_slot] = it.table_word;
      return 1'b0;
    end
    if (char_len != 0) begin
      char_acc = {char_acc[23:0], it.text_byte};
      char_got = char_got + 3'd1;
      if (char_got < char_len) return 1'b0;
      res.glyph_index = match_code(char_acc);
      res.bytes_used = char_len;
      char_acc = '0;
      char_len = '0;
      char_got = '0;
      return 1'b1;
    end
    if (it.text_byte < ASCII_LIM) begin
      res.glyph_index = match_code({24'h0, it.text_byte});
      res.bytes_used = 3'd1;
      return 1'b1;
    end
    case (it.text_byte[7:4])
      LEAD_TWO: char_len = 3'd2;
      LEAD_THREE: char_len = 3'd3;
      LEAD_FOUR: char_len = 3'd4;
      default: begin
        res.glyph_index = NO_GLYPH;
        res.bytes_used = 3'd1;
        return 1'b1;
      end
    endcase
    char_acc = {24'h0, it.text_byte};
    char_got = 3'd1;
    return 1'b0;
  endfunction

  function automatic int code_len(logic [31:0] c);
    if (c < {24'h0, ASCII_LIM}) return 1;
    if (c[31:16] == 16'h0 && c[15:12] == LEAD_TWO) return 2;
    if (c[31:24] == 8'h0 && c[23:20] == LEAD_THREE) return 3;
    if (c[31:28] == LEAD_FOUR) return 4;
    return 0;
  endfunction

  function automatic logic [7:0] trail_byte();
    if ($urandom_range(0, 99) < 85) return {2'b10, 6'($urandom)};
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] make_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return {25'h0, 7'($urandom)};
    if (r < 50) return {16'h0, LEAD_TWO, 4'($urandom), trail_byte()};
    if (r < 75) return {8'h0, LEAD_THREE, 4'($urandom), trail_byte(), trail_byte()};
    if (r < 95) return {LEAD_FOUR, 4'($urandom), trail_byte(), trail_byte(), trail_byte()};
    return 32'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t text_item(logic [7:0] b);
    return '{OP_TEXT, 8'($urandom), 32'($urandom), b};
  endfunction

  function automatic in_item_t load_item(logic [7:0] slot, logic [31:0] word);
    return '{OP_LOAD, slot, word, 8'($urandom)};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(input in_item_t it, input bit use_want = 1'b0,
                           input out_item_t want = '0);
    int gap;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    item = it;
    do @(posedge clk); while (full);
    sent++;
    if (next_glyph(it, res)) due_glyphs.push_back(use_want ? want : res);
    @(negedge clk);
  endtask

  task automatic settle();
    push = 1'b0;
    while (due_glyphs.size() != due_head) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_table_size(logic [CNT_W-1:0] v);
    settle();
    // trailing loads may still sit in the command queue
    repeat (search_span() + 8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    search_len = v;
  endtask

  task automatic send_char(logic [31:0] code, int len);
    for (int k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(0, 19) == 0)
        push_item(load_item(8'($urandom), make_code()));
      push_item(text_item(8'(code >> (8 * (len - 1 - k)))));
    end
  endtask

  task automatic run_text_phase(int n);
    int stop;
    int mid;
    int r;
    bit held_off;
    logic [31:0] code;
    logic [31:0] pick;
    stop = sent + n;
    mid = sent + n / 2;
    held_off = 1'b0;
    while (sent < stop) begin
      if (!held_off && sent >= mid) begin
        settle();
        held_off = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_item(load_item(8'($urandom),
                            ($urandom_range(0, 3) == 0) ? 32'($urandom) : make_code()));
      end else if (r < 14) begin
        push_item(text_item($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hD0, 8'hDF))));
      end else if (r < 20) begin
        push_item(text_item(8'($urandom)));
      end else begin
        code = make_code();
        if (search_span() > 0 && $urandom_range(0, 1) == 1) begin
          pick = font_codes[8'($urandom_range(0, search_span() - 1))];
          if (code_len(pick) != 0) code = pick;
        end
        while (code_len(code) == 0) code = make_code();
        send_char(code, code_len(code));
      end
    end
    // finish any open character before the next size change
    while (char_len != 0) push_item(text_item(8'($urandom)));
  endtask

  task automatic check_glyph(out_item_t got);
    out_item_t want;
    if (due_head >= due_glyphs.size()) begin
      bad_count++;
      if (bad_count <= REPORT_MAX)
        $display("unexpected result: index %0d bytes %0d", got.glyph_index, got.bytes_used);
      return;
    end
    want = due_glyphs[due_head];
    due_head++;
    if (got.glyph_index !== want.glyph_index || got.bytes_used !== want.bytes_used) begin
      bad_count++;
      if (bad_count <= REPORT_MAX)
        $display("mismatch: expected index %0d bytes %0d, got index %0d bytes %0d",
                 want.glyph_index, want.bytes_used, got.glyph_index, got.bytes_used);
    end
  endtask

  always @(negedge clk) begin
    if (pops_done != pops_seen) begin
      pops_done = pops_seen;
      rx_stall = rx_gap;
    end
    if (rx_stall > 0) begin
      pop = 1'b0;
      rx_stall--;
    end else begin
      pop = !rst;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      check_glyph(result);
      rx_gap = pick_gap();
      pops_seen++;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_CFG)
        set_table_size(dir_plan[i].size);
      else
        push_item(dir_plan[i].it, dir_plan[i].typed_exp, dir_plan[i].want);
    end

    // fill the whole table so any size is safe to search; some codes repeat
    for (int s = 0; s < DEPTH; s++)
      push_item(load_item(s[7:0], (s > 0 && $urandom_range(0, 6) == 0)
                                  ? font_codes[8'($urandom_range(0, s - 1))] : make_code()));

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 4 || p == 7);
      set_table_size(phase_size[p]);
      run_text_phase(phase_items[p]);
    end
    quiet = 1'b0;

    settle();
    repeat (300) @(posedge clk);
    if (bad_count == 0 && due_glyphs.size() == due_head)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
